@@ hw/rtl/dnstok_pkg.sv @@
// Types and constants shared by the DNS message section tokenizer.
`default_nettype none

package dnstok_pkg;

  // Fixed message layout
  localparam int unsigned HEADER_BYTES         = 12;
  localparam int unsigned QUESTION_FIXED_BYTES = 4;
  localparam int unsigned RECORD_FIXED_BYTES   = 10;
  localparam int unsigned NUM_SECTIONS         = 4;

  // Name byte codes
  localparam logic [7:0] NAME_END_BYTE = 8'h00;
  localparam logic [7:0] POINTER_MASK  = 8'hC0;

  typedef enum logic [2:0] {
    SEC_HEADER     = 3'd0,
    SEC_QUESTION   = 3'd1,
    SEC_ANSWER     = 3'd2,
    SEC_AUTHORITY  = 3'd3,
    SEC_ADDITIONAL = 3'd4,
    SEC_TRAILING   = 3'd5
  } section_t;

  typedef enum logic [2:0] {
    PART_HEADER  = 3'd0,
    PART_LABEL   = 3'd1,
    PART_POINTER = 3'd2,
    PART_FIXED   = 3'd3,
    PART_DATA    = 3'd4
  } part_t;

  typedef enum logic [1:0] {
    PHASE_LENGTH  = 2'd0,
    PHASE_LABEL   = 2'd1,
    PHASE_POINTER = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  section;
    logic [2:0]  part;
    logic [15:0] element_index;
    logic        element_end;
    logic        message_end;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/dns_message_section_tokenizer_top.sv @@
// Top level of the DNS message section tokenizer: byte tagging datapath.
`default_nettype none

// Tags each byte of a DNS message with its section (header, question,
// answer, authority, additional or trailing), its part (header, name label,
// name pointer, fixed part, record data), the index of its question or
// record, and end-of-element / end-of-message flags. One result leaves for
// every byte that enters, in order. A byte is registered on entry, then the
// tokenizer state and the tag are worked out combinationally and land in the
// output register, so the block sustains one byte per clock while out_stall
// is low; the only limit is the single state update per byte.
// start_of_message abandons any message in flight and makes that byte
// header byte 0. Bytes seen after reset and before the first start, or after
// the end of a message, are tagged trailing. Both channels use valid/stall;
// out_stall holding off the output register backs up into in_stall, and a
// byte is still taken while a result is being transferred out.
module dns_message_section_tokenizer_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  dnstok_pkg::in_item_t    in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output dnstok_pkg::out_item_t   out_data
);

  // Input register
  logic                 in_valid_r;
  dnstok_pkg::in_item_t in_r;
  logic                 advance;

  // Output register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  dnstok_pkg::out_item_t out_r;
  dnstok_pkg::out_item_t out_nxt;

  // Tokenizer state
  dnstok_pkg::section_t section_r, section_nxt;
  dnstok_pkg::part_t    part_r, part_nxt;
  dnstok_pkg::phase_t   phase_r, phase_nxt;
  logic [15:0]          counts_r [dnstok_pkg::NUM_SECTIONS];
  logic [15:0]          counts_nxt [dnstok_pkg::NUM_SECTIONS];
  logic [15:0]          elem_r, elem_nxt;
  logic [15:0]          left_r, left_nxt;
  logic [3:0]           hpos_r, hpos_nxt;
  logic [7:0]           lenhi_r, lenhi_nxt;

  // The stage holding a byte moves on when the output register is free
  // or is being emptied this cycle.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic                 som;
    logic [7:0]           b;
    dnstok_pkg::section_t sec_cur;
    dnstok_pkg::part_t    part_cur;
    dnstok_pkg::phase_t   phase_cur;
    logic [15:0]          elem_cur;
    logic [15:0]          left_cur;
    logic [3:0]           hpos_cur;
    logic [7:0]           lenhi_cur;
    logic [3:0]           pos_m4;
    logic [15:0]          left_dec;
    logic [15:0]          elem_inc;
    logic [1:0]           cnt_idx;
    logic                 is_question;
    logic                 do_close;
    logic                 do_enter;
    logic [2:0]           enter_from;
    logic                 found;
    dnstok_pkg::section_t found_sec;
    logic [15:0]          dlen;

    b   = in_r.data_byte;
    som = in_r.start_of_message;

    // A start marker restarts the whole tokenizer at header byte 0
    sec_cur   = som ? dnstok_pkg::SEC_HEADER   : section_r;
    part_cur  = som ? dnstok_pkg::PART_HEADER  : part_r;
    phase_cur = som ? dnstok_pkg::PHASE_LENGTH : phase_r;
    elem_cur  = som ? 16'd0 : elem_r;
    left_cur  = som ? 16'd0 : left_r;
    hpos_cur  = som ? 4'd0  : hpos_r;
    lenhi_cur = som ? 8'd0  : lenhi_r;
    for (int i = 0; i < dnstok_pkg::NUM_SECTIONS; i++) begin
      counts_nxt[2'(i)] = som ? 16'd0 : counts_r[2'(i)];
    end

    section_nxt = sec_cur;
    part_nxt    = part_cur;
    phase_nxt   = phase_cur;
    elem_nxt    = elem_cur;
    left_nxt    = left_cur;
    hpos_nxt    = hpos_cur;
    lenhi_nxt   = lenhi_cur;

    pos_m4      = hpos_cur - 4'd4;
    left_dec    = left_cur - 16'd1;
    elem_inc    = elem_cur + 16'd1;
    cnt_idx     = 2'(sec_cur - 3'd1);
    is_question = (sec_cur == dnstok_pkg::SEC_QUESTION);
    do_close    = 1'b0;
    do_enter    = 1'b0;
    enter_from  = 3'd1;
    dlen        = 16'd0;

    out_nxt.section       = sec_cur;
    out_nxt.part          = dnstok_pkg::PART_HEADER;
    out_nxt.element_index = elem_cur;
    out_nxt.element_end   = 1'b0;
    out_nxt.message_end   = 1'b0;

    case (sec_cur)
      dnstok_pkg::SEC_HEADER: begin
        out_nxt.element_index = 16'd0;
        // Count fields are big-endian pairs at bytes 4 to 11
        if (hpos_cur >= 4'd4 && hpos_cur < 4'(dnstok_pkg::HEADER_BYTES)) begin
          if (!hpos_cur[0]) begin
            lenhi_nxt = b;
          end else begin
            counts_nxt[pos_m4[2:1]] = {lenhi_cur, b};
          end
        end
        if (hpos_cur >= 4'(dnstok_pkg::HEADER_BYTES - 1)) begin
          out_nxt.element_end = 1'b1;
          hpos_nxt   = 4'd0;
          do_enter   = 1'b1;
          enter_from = 3'd1;
        end else begin
          hpos_nxt = hpos_cur + 4'd1;
        end
      end
      dnstok_pkg::SEC_QUESTION, dnstok_pkg::SEC_ANSWER,
      dnstok_pkg::SEC_AUTHORITY, dnstok_pkg::SEC_ADDITIONAL: begin
        if (part_cur == dnstok_pkg::PART_FIXED) begin
          out_nxt.part = dnstok_pkg::PART_FIXED;
          if (!is_question && left_cur == 16'd2) begin
            lenhi_nxt = b;
          end
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            if (!is_question) begin
              dlen = {lenhi_nxt, b};
            end
            if (dlen == 16'd0) begin
              // record with no data ends on its last fixed byte
              out_nxt.element_end = 1'b1;
              do_close = 1'b1;
            end else begin
              part_nxt = dnstok_pkg::PART_DATA;
              left_nxt = dlen;
            end
          end
        end else if (part_cur == dnstok_pkg::PART_DATA) begin
          out_nxt.part = dnstok_pkg::PART_DATA;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            out_nxt.element_end = 1'b1;
            do_close = 1'b1;
          end
        end else if (phase_cur == dnstok_pkg::PHASE_LABEL) begin
          out_nxt.part = dnstok_pkg::PART_LABEL;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = dnstok_pkg::PHASE_LENGTH;
          end
        end else if (phase_cur == dnstok_pkg::PHASE_POINTER) begin
          // second pointer byte closes the name
          out_nxt.part = dnstok_pkg::PART_POINTER;
          part_nxt  = dnstok_pkg::PART_FIXED;
          phase_nxt = dnstok_pkg::PHASE_LENGTH;
          left_nxt  = is_question ? 16'(dnstok_pkg::QUESTION_FIXED_BYTES)
                                  : 16'(dnstok_pkg::RECORD_FIXED_BYTES);
        end else if (b == dnstok_pkg::NAME_END_BYTE) begin
          out_nxt.part = dnstok_pkg::PART_LABEL;
          part_nxt  = dnstok_pkg::PART_FIXED;
          phase_nxt = dnstok_pkg::PHASE_LENGTH;
          left_nxt  = is_question ? 16'(dnstok_pkg::QUESTION_FIXED_BYTES)
                                  : 16'(dnstok_pkg::RECORD_FIXED_BYTES);
        end else if ((b & dnstok_pkg::POINTER_MASK) == dnstok_pkg::POINTER_MASK) begin
          out_nxt.part = dnstok_pkg::PART_POINTER;
          part_nxt  = dnstok_pkg::PART_LABEL;
          phase_nxt = dnstok_pkg::PHASE_POINTER;
        end else begin
          // label length; reserved type bits count as part of the length
          out_nxt.part = dnstok_pkg::PART_LABEL;
          part_nxt  = dnstok_pkg::PART_LABEL;
          left_nxt  = {8'd0, b};
          phase_nxt = dnstok_pkg::PHASE_LABEL;
        end
      end
      default: begin
        out_nxt.section       = dnstok_pkg::SEC_TRAILING;
        out_nxt.element_index = 16'd0;
      end
    endcase

    // Closing an element: next one in this section, or on to the next section
    if (do_close) begin
      elem_nxt = elem_inc;
      if (elem_inc >= counts_nxt[cnt_idx]) begin
        do_enter   = 1'b1;
        enter_from = sec_cur + 3'd1;
      end else begin
        part_nxt  = dnstok_pkg::PART_LABEL;
        phase_nxt = dnstok_pkg::PHASE_LENGTH;
      end
    end

    // First section from enter_from on with a nonzero count
    found     = 1'b0;
    found_sec = dnstok_pkg::SEC_TRAILING;
    for (int s = 1; s <= dnstok_pkg::NUM_SECTIONS; s++) begin
      if (!found && 3'(s) >= enter_from && counts_nxt[2'(s - 1)] != 16'd0) begin
        found     = 1'b1;
        found_sec = dnstok_pkg::section_t'(3'(s));
      end
    end

    if (do_enter) begin
      elem_nxt  = 16'd0;
      phase_nxt = dnstok_pkg::PHASE_LENGTH;
      if (found) begin
        section_nxt = found_sec;
        part_nxt    = dnstok_pkg::PART_LABEL;
      end else begin
        section_nxt         = dnstok_pkg::SEC_TRAILING;
        part_nxt            = dnstok_pkg::PART_HEADER;
        out_nxt.message_end = 1'b1;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      section_r   <= dnstok_pkg::SEC_TRAILING;
      part_r      <= dnstok_pkg::PART_HEADER;
      phase_r     <= dnstok_pkg::PHASE_LENGTH;
      elem_r      <= 16'd0;
      left_r      <= 16'd0;
      hpos_r      <= 4'd0;
      lenhi_r     <= 8'd0;
      for (int i = 0; i < dnstok_pkg::NUM_SECTIONS; i++) begin
        counts_r[2'(i)] <= 16'd0;
      end
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        section_r <= section_nxt;
        part_r    <= part_nxt;
        phase_r   <= phase_nxt;
        elem_r    <= elem_nxt;
        left_r    <= left_nxt;
        hpos_r    <= hpos_nxt;
        lenhi_r   <= lenhi_nxt;
        for (int i = 0; i < dnstok_pkg::NUM_SECTIONS; i++) begin
          counts_r[2'(i)] <= counts_nxt[2'(i)];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
